// File: hdl/matc_pkg.sv
// ----------------------------------------------------------------------------
// matc_pkg
// Shared types, codes and helpers for the motor axis torque controller:
// widths, mode and register codes, sequencer states, MAC controls, saturation.
// ----------------------------------------------------------------------------
package matc_pkg;

    // Data widths (signed Q16.16 words and internal extensions)
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int GEAR_W    = 31;
    localparam int OPND_W    = DATA_W + 1;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int ACC_W     = 56;
    localparam int DIV_NUM_W = DATA_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
    localparam int CFG_IDX_W = 2;

    // Reset values of the configuration registers
    localparam logic [GEAR_W-1:0]        GEAR_RATIO_RST    = GEAR_W'(65536);
    localparam logic signed [DATA_W-1:0] POSITION_GAIN_RST = DATA_W'(6553600);
    localparam logic signed [DATA_W-1:0] VELOCITY_GAIN_RST = DATA_W'(327680);
    localparam logic signed [DATA_W-1:0] INTEGRAL_GAIN_RST = '0;

    // Saturation bounds at accumulator width
    localparam logic signed [ACC_W-1:0] ACC_DATA_MAX = ACC_W'(2**(DATA_W-1) - 1);
    localparam logic signed [ACC_W-1:0] ACC_DATA_MIN = -ACC_DATA_MAX - ACC_W'(1);

    // Item kinds
    localparam logic ACTION_COMMAND = 1'b0;
    localparam logic ACTION_TICK    = 1'b1;

    // Valid flag positions
    localparam int FLAG_POS  = 0;
    localparam int FLAG_VEL  = 1;
    localparam int FLAG_TORQ = 2;

    typedef enum logic [1:0] {
        MODE_KEEP     = 2'd0,
        MODE_POSITION = 2'd1,
        MODE_VELOCITY = 2'd2,
        MODE_TORQUE   = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GEAR_RATIO    = 2'd0,
        REG_POSITION_GAIN = 2'd1,
        REG_VELOCITY_GAIN = 2'd2,
        REG_INTEGRAL_GAIN = 2'd3
    } reg_index_t;

    // Accumulator operations of the shared MAC
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_SET,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        logic    mul_en;
        acc_op_t acc_op;
    } mac_ctrl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMD_MUL_POS,
        S_CMD_MUL_VEL,
        S_CMD_POS,
        S_CMD_VEL,
        S_CMD_DIV,
        S_POS_MUL_I,
        S_POS_INT,
        S_POS_SUM,
        S_POS_ADD_D,
        S_VEL_MUL,
        S_VEL_SUM,
        S_PASS,
        S_FINISH
    } state_t;

    // Clamp an accumulator value to the signed data range
    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > ACC_DATA_MAX)
            r = ACC_DATA_MAX[DATA_W-1:0];
        else if (v < ACC_DATA_MIN)
            r = ACC_DATA_MIN[DATA_W-1:0];
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

// File: hdl/matc_item_if.sv
// ----------------------------------------------------------------------------
// matc_item_if
// Input channel: command and tick items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface matc_item_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 action;
    logic [1:0]                           mode_request;
    logic signed [matc_pkg::DATA_W-1:0]   pos_demand;
    logic signed [matc_pkg::DATA_W-1:0]   vel_demand;
    logic signed [matc_pkg::DATA_W-1:0]   torq_demand;
    logic                                 pos_set_valid;
    logic                                 vel_set_valid;
    logic                                 torq_set_valid;
    logic signed [matc_pkg::DATA_W-1:0]   measured_pos;
    logic signed [matc_pkg::DATA_W-1:0]   measured_vel;

    modport source (
        output valid, action, mode_request, pos_demand, vel_demand, torq_demand,
               pos_set_valid, vel_set_valid, torq_set_valid, measured_pos, measured_vel,
        input  ready
    );

    modport sink (
        input  valid, action, mode_request, pos_demand, vel_demand, torq_demand,
               pos_set_valid, vel_set_valid, torq_set_valid, measured_pos, measured_vel,
        output ready
    );
endinterface

// File: hdl/matc_result_if.sv
// ----------------------------------------------------------------------------
// matc_result_if
// Output channel: drive torque results with valid/ready handshake.
// ----------------------------------------------------------------------------
interface matc_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [matc_pkg::DATA_W-1:0]   drive_torque;
    logic                                 drive_updated;

    modport source (
        output valid, drive_torque, drive_updated,
        input  ready
    );

    modport sink (
        input  valid, drive_torque, drive_updated,
        output ready
    );
endinterface

// File: hdl/motor_axis_torque_controller_core.sv
// ----------------------------------------------------------------------------
// motor_axis_torque_controller_core
// Position / velocity / torque control law for one motor axis in signed
// Q16.16, run by a small sequencer over one shared MAC and a serial divider.
//
//   Channel   Direction  Handshake        Payload
//   item      in         valid/ready      action, mode, setpoints, flags, measures
//   result    out        valid/ready      drive_torque, drive_updated
//   cfg       in         cfg_write_en     cfg_index, cfg_data (no read-back)
//
// A tick runs from transfer to result register along a path set by the mode (position mode
// longest: three passes through the shared multiplier plus summing).
// A command holds the sequencer after its transfer until the 48-step divider
// for the torque target has finished. The item side is ready only while
// the sequencer is idle.
// A result waiting in the output register stalls only the next tick's finish.
// Reset is asynchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module motor_axis_torque_controller_core (
    input  logic                                     clk,
    input  logic                                     rst_n,
    matc_item_if.sink                                item,
    matc_result_if.source                            result,
    input  logic                                     cfg_write_en,
    input  logic [matc_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [matc_pkg::DATA_W-1:0]              cfg_data
);

    localparam int DW = matc_pkg::DATA_W;
    localparam int OW = matc_pkg::OPND_W;
    localparam int AW = matc_pkg::ACC_W;
    localparam int GW = matc_pkg::GEAR_W;

    // Configuration registers
    logic [GW-1:0]          gear_ratio_reg;
    logic signed [DW-1:0]   position_gain_reg;
    logic signed [DW-1:0]   velocity_gain_reg;
    logic signed [DW-1:0]   integral_gain_reg;

    // Controller state
    matc_pkg::state_t       state_reg, state_next;
    matc_pkg::mode_t        mode_reg, mode_next;
    logic signed [DW-1:0]   pos_target_reg, pos_target_next;
    logic signed [DW-1:0]   vel_target_reg, vel_target_next;
    logic signed [DW-1:0]   torq_target_reg, torq_target_next;
    logic [2:0]             flags_reg, flags_next;
    logic signed [DW-1:0]   integral_reg, integral_next;
    logic signed [DW-1:0]   last_drive_reg, last_drive_next;
    logic                   ok_reg, ok_next;

    // Held item fields
    logic [1:0]             mode_req_reg, mode_req_next;
    logic signed [DW-1:0]   pos_set_reg, pos_set_next;
    logic signed [DW-1:0]   vel_set_reg, vel_set_next;
    logic signed [DW-1:0]   torq_set_reg, torq_set_next;
    logic [2:0]             set_flags_reg, set_flags_next;
    logic signed [DW-1:0]   meas_pos_reg, meas_pos_next;
    logic signed [DW-1:0]   meas_vel_reg, meas_vel_next;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic signed [DW-1:0]   out_drive_reg, out_drive_next;
    logic                   out_updated_reg, out_updated_next;

    // Shared units
    matc_pkg::mac_ctrl_t    mac_ctrl;
    logic signed [OW-1:0]   opnd_a;
    logic signed [OW-1:0]   opnd_b;
    logic signed [AW-1:0]   addend;
    logic signed [AW-1:0]   mac_acc;
    logic signed [DW-1:0]   acc_sat;
    logic                   div_start;
    logic                   div_busy;
    logic signed [DW-1:0]   div_quotient;

    logic                   item_fire;
    logic signed [OW-1:0]   pos_err;
    logic signed [OW-1:0]   vel_err;
    logic signed [OW-1:0]   gear_opnd;

    assign item_fire = item.valid && item.ready;
    assign item.ready = (state_reg == matc_pkg::S_IDLE);

    assign pos_err   = OW'(pos_target_reg) - OW'(meas_pos_reg);
    assign vel_err   = OW'(vel_target_reg) - OW'(meas_vel_reg);
    assign gear_opnd = {2'b00, gear_ratio_reg};
    assign acc_sat   = matc_pkg::sat_data(mac_acc);

    matc_mac u_mac (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .opnd_a (opnd_a),
        .opnd_b (opnd_b),
        .addend (addend),
        .acc    (mac_acc)
    );

    matc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (torq_set_reg),
        .divisor  (gear_ratio_reg),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // Write configuration registers; a zero gear ratio is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gear_ratio_reg    <= matc_pkg::GEAR_RATIO_RST;
            position_gain_reg <= matc_pkg::POSITION_GAIN_RST;
            velocity_gain_reg <= matc_pkg::VELOCITY_GAIN_RST;
            integral_gain_reg <= matc_pkg::INTEGRAL_GAIN_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (matc_pkg::reg_index_t'(cfg_index))
                matc_pkg::REG_GEAR_RATIO:
                begin
                    if (|cfg_data[GW-1:0])
                    begin
                        gear_ratio_reg <= cfg_data[GW-1:0];
                    end
                end
                matc_pkg::REG_POSITION_GAIN: position_gain_reg <= cfg_data;
                matc_pkg::REG_VELOCITY_GAIN: velocity_gain_reg <= cfg_data;
                matc_pkg::REG_INTEGRAL_GAIN: integral_gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: next state, unit controls and state updates
    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        pos_target_next  = pos_target_reg;
        vel_target_next  = vel_target_reg;
        torq_target_next = torq_target_reg;
        flags_next       = flags_reg;
        integral_next    = integral_reg;
        last_drive_next  = last_drive_reg;
        ok_next          = ok_reg;
        mode_req_next    = mode_req_reg;
        pos_set_next     = pos_set_reg;
        vel_set_next     = vel_set_reg;
        torq_set_next    = torq_set_reg;
        set_flags_next   = set_flags_reg;
        meas_pos_next    = meas_pos_reg;
        meas_vel_next    = meas_vel_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_drive_next   = out_drive_reg;
        out_updated_next = out_updated_reg;
        mac_ctrl.mul_en  = 1'b0;
        mac_ctrl.acc_op  = matc_pkg::ACC_HOLD;
        opnd_a           = '0;
        opnd_b           = '0;
        addend           = '0;
        div_start        = 1'b0;

        unique case (state_reg)
            matc_pkg::S_IDLE:
            begin
                // Capture the item and pick the path
                if (item_fire)
                begin
                    mode_req_next  = item.mode_request;
                    pos_set_next   = item.pos_demand;
                    vel_set_next   = item.vel_demand;
                    torq_set_next  = item.torq_demand;
                    set_flags_next = {item.torq_set_valid, item.vel_set_valid,
                                      item.pos_set_valid};
                    meas_pos_next  = item.measured_pos;
                    meas_vel_next  = item.measured_vel;
                    if (item.action == matc_pkg::ACTION_COMMAND)
                    begin
                        state_next = matc_pkg::S_CMD_MUL_POS;
                    end
                    else
                    begin
                        unique case (mode_reg) inside
                            matc_pkg::MODE_POSITION:
                            begin
                                ok_next    = &flags_reg;
                                state_next = (&flags_reg) ? matc_pkg::S_POS_MUL_I
                                                          : matc_pkg::S_PASS;
                            end
                            matc_pkg::MODE_VELOCITY:
                            begin
                                ok_next    = flags_reg[matc_pkg::FLAG_VEL]
                                             && flags_reg[matc_pkg::FLAG_TORQ];
                                state_next = (flags_reg[matc_pkg::FLAG_VEL]
                                              && flags_reg[matc_pkg::FLAG_TORQ])
                                             ? matc_pkg::S_VEL_MUL : matc_pkg::S_PASS;
                            end
                            matc_pkg::MODE_TORQUE, matc_pkg::MODE_KEEP:
                            begin
                                ok_next    = flags_reg[matc_pkg::FLAG_TORQ];
                                state_next = matc_pkg::S_PASS;
                            end
                            default: ;
                        endcase
                    end
                end
            end

            // Command: scale position, velocity, divide torque
            matc_pkg::S_CMD_MUL_POS:
            begin
                mac_ctrl.mul_en = 1'b1;
                opnd_a          = OW'(pos_set_reg);
                opnd_b          = gear_opnd;
                state_next      = matc_pkg::S_CMD_MUL_VEL;
            end
            matc_pkg::S_CMD_MUL_VEL:
            begin
                mac_ctrl.acc_op = matc_pkg::ACC_LOAD;
                mac_ctrl.mul_en = 1'b1;
                opnd_a          = OW'(vel_set_reg);
                opnd_b          = gear_opnd;
                div_start       = 1'b1;
                state_next      = matc_pkg::S_CMD_POS;
            end
            matc_pkg::S_CMD_POS:
            begin
                pos_target_next = acc_sat;
                mac_ctrl.acc_op = matc_pkg::ACC_LOAD;
                state_next      = matc_pkg::S_CMD_VEL;
            end
            matc_pkg::S_CMD_VEL:
            begin
                vel_target_next = acc_sat;
                state_next      = matc_pkg::S_CMD_DIV;
            end
            matc_pkg::S_CMD_DIV:
            begin
                // Hold until the quotient is complete, then commit
                if (!div_busy)
                begin
                    torq_target_next = div_quotient;
                    flags_next       = set_flags_reg;
                    if (mode_req_reg != matc_pkg::MODE_KEEP)
                    begin
                        mode_next = matc_pkg::mode_t'(mode_req_reg);
                    end
                    state_next = matc_pkg::S_IDLE;
                end
            end

            // Position tick: integral, then kp and kd terms
            matc_pkg::S_POS_MUL_I:
            begin
                mac_ctrl.mul_en = 1'b1;
                opnd_a          = pos_err;
                opnd_b          = OW'(integral_gain_reg);
                state_next      = matc_pkg::S_POS_INT;
            end
            matc_pkg::S_POS_INT:
            begin
                mac_ctrl.acc_op = matc_pkg::ACC_LOAD;
                addend          = AW'(integral_reg);
                mac_ctrl.mul_en = 1'b1;
                opnd_a          = pos_err;
                opnd_b          = OW'(position_gain_reg);
                state_next      = matc_pkg::S_POS_SUM;
            end
            matc_pkg::S_POS_SUM:
            begin
                integral_next   = acc_sat;
                mac_ctrl.acc_op = matc_pkg::ACC_LOAD;
                addend          = AW'(torq_target_reg) + AW'(acc_sat);
                mac_ctrl.mul_en = 1'b1;
                opnd_a          = vel_err;
                opnd_b          = OW'(velocity_gain_reg);
                state_next      = matc_pkg::S_POS_ADD_D;
            end
            matc_pkg::S_POS_ADD_D:
            begin
                mac_ctrl.acc_op = matc_pkg::ACC_ADD;
                state_next      = matc_pkg::S_FINISH;
            end

            // Velocity tick: kp on velocity error
            matc_pkg::S_VEL_MUL:
            begin
                mac_ctrl.mul_en = 1'b1;
                opnd_a          = vel_err;
                opnd_b          = OW'(position_gain_reg);
                state_next      = matc_pkg::S_VEL_SUM;
            end
            matc_pkg::S_VEL_SUM:
            begin
                mac_ctrl.acc_op = matc_pkg::ACC_LOAD;
                addend          = AW'(torq_target_reg);
                state_next      = matc_pkg::S_FINISH;
            end

            // Torque pass-through or hold of the previous drive
            matc_pkg::S_PASS:
            begin
                mac_ctrl.acc_op = matc_pkg::ACC_SET;
                addend          = ok_reg ? AW'(torq_target_reg) : AW'(last_drive_reg);
                state_next      = matc_pkg::S_FINISH;
            end

            matc_pkg::S_FINISH:
            begin
                // Load the result once the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_drive_next   = acc_sat;
                    out_updated_next = ok_reg;
                    last_drive_next  = acc_sat;
                    state_next       = matc_pkg::S_IDLE;
                end
            end

            default: state_next = matc_pkg::S_IDLE;
        endcase
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= matc_pkg::S_IDLE;
            mode_reg        <= matc_pkg::MODE_TORQUE;
            pos_target_reg  <= '0;
            vel_target_reg  <= '0;
            torq_target_reg <= '0;
            flags_reg       <= 3'b111;
            integral_reg    <= '0;
            last_drive_reg  <= '0;
            ok_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            pos_target_reg  <= pos_target_next;
            vel_target_reg  <= vel_target_next;
            torq_target_reg <= torq_target_next;
            flags_reg       <= flags_next;
            integral_reg    <= integral_next;
            last_drive_reg  <= last_drive_next;
            ok_reg          <= ok_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_req_reg    <= mode_req_next;
        pos_set_reg     <= pos_set_next;
        vel_set_reg     <= vel_set_next;
        torq_set_reg    <= torq_set_next;
        set_flags_reg   <= set_flags_next;
        meas_pos_reg    <= meas_pos_next;
        meas_vel_reg    <= meas_vel_next;
        out_drive_reg   <= out_drive_next;
        out_updated_reg <= out_updated_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.drive_torque  = out_drive_reg;
    assign result.drive_updated = out_updated_reg;

    // The divider runs only under a command sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == matc_pkg::S_IDLE) |-> !div_busy)
        else $error("divider busy while sequencer idle");

    // A shown result always equals the held drive value
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.drive_torque == last_drive_reg))
        else $error("result differs from held drive");

    // A command transfer never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && (item.action == matc_pkg::ACTION_COMMAND) && !result.valid)
        |=> !result.valid)
        else $error("result raised by a command");

    // The gear ratio never becomes zero
    assert property (@(posedge clk) disable iff (!rst_n)
        gear_ratio_reg != '0)
        else $error("zero gear ratio stored");

endmodule

// File: hdl/matc_mac.sv
// ----------------------------------------------------------------------------
// matc_mac
// Shared multiply-accumulate unit: registered 33x33 signed product, scaled by
// 2^-16 with floor rounding, and a wide accumulator.
// ----------------------------------------------------------------------------
module matc_mac (
    input  logic                                 clk,
    input  matc_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [matc_pkg::OPND_W-1:0]   opnd_a,
    input  logic signed [matc_pkg::OPND_W-1:0]   opnd_b,
    input  logic signed [matc_pkg::ACC_W-1:0]    addend,
    output logic signed [matc_pkg::ACC_W-1:0]    acc
);

    localparam int SCALED_W = matc_pkg::PROD_W - matc_pkg::FRAC_W;

    logic signed [matc_pkg::PROD_W-1:0] prod_reg;
    logic signed [matc_pkg::PROD_W-1:0] prod_next;
    logic signed [matc_pkg::ACC_W-1:0]  acc_reg;
    logic signed [matc_pkg::ACC_W-1:0]  acc_next;
    logic signed [matc_pkg::ACC_W-1:0]  scaled;

    // Form the exact product
    assign prod_next = opnd_a * opnd_b;

    // Drop the fraction bits, arithmetic shift rounds toward minus infinity
    assign scaled = {{(matc_pkg::ACC_W - SCALED_W){prod_reg[matc_pkg::PROD_W-1]}},
                     prod_reg[matc_pkg::PROD_W-1:matc_pkg::FRAC_W]};

    // Select the accumulator update
    always_comb
    begin
        case (ctrl.acc_op)
            matc_pkg::ACC_SET:  acc_next = addend;
            matc_pkg::ACC_LOAD: acc_next = addend + scaled;
            matc_pkg::ACC_ADD:  acc_next = acc_reg + scaled;
            default:            acc_next = acc_reg;
        endcase
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// File: hdl/matc_div.sv
// ----------------------------------------------------------------------------
// matc_div
// Radix-2 restoring divider for the torque target: (dividend * 2^16) / divisor
// truncated toward zero and saturated to 32 bits, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module matc_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [matc_pkg::DATA_W-1:0]   dividend,
    input  logic [matc_pkg::GEAR_W-1:0]          divisor,
    output logic                                 busy,
    output logic signed [matc_pkg::DATA_W-1:0]   quotient
);

    localparam int NUM_W = matc_pkg::DIV_NUM_W;
    localparam int CNT_W = matc_pkg::DIV_CNT_W;
    localparam int DW    = matc_pkg::DATA_W;
    localparam int GW    = matc_pkg::GEAR_W;

    logic               busy_reg;
    logic               busy_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [GW-1:0]      rem_reg;
    logic [GW-1:0]      rem_next;
    logic [NUM_W-1:0]   shift_reg;
    logic [NUM_W-1:0]   shift_next;
    logic               neg_reg;
    logic               neg_next;
    logic [DW-1:0]      magnitude;
    logic [GW+1:0]      trial;
    logic               fits;

    assign magnitude = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);

    // Trial subtract of the divisor from the partial remainder
    assign trial = {1'b0, rem_reg, shift_reg[NUM_W-1]} - {2'b00, divisor};
    assign fits  = !trial[GW+1];

    // Load or advance one quotient bit
    always_comb
    begin
        busy_next  = busy_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        neg_next   = neg_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            shift_next = {magnitude, {matc_pkg::FRAC_W{1'b0}}};
            neg_next   = dividend[DW-1];
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? trial[GW-1:0] : {rem_reg[GW-2:0], shift_reg[NUM_W-1]};
            shift_next = {shift_reg[NUM_W-2:0], fits};
            count_next = count_reg + CNT_W'(1);
            if (count_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        neg_reg   <= neg_next;
    end

    // Apply the sign and clamp the quotient magnitude
    always_comb
    begin
        if (neg_reg)
        begin
            if ((|shift_reg[NUM_W-1:DW]) || (shift_reg[DW-1] && (|shift_reg[DW-2:0])))
                quotient = {1'b1, {(DW-1){1'b0}}};
            else
                quotient = DW'(-shift_reg[DW-1:0]);
        end
        else
        begin
            if (|shift_reg[NUM_W-1:DW-1])
                quotient = {1'b0, {(DW-1){1'b1}}};
            else
                quotient = shift_reg[DW-1:0];
        end
    end

    assign busy = busy_reg;

endmodule
